FILE: design/locked_background_subtractor_defines.svh
// Assertion macros used by the checker of the background subtractor.
// Needs a clk signal in the scope of each use; no other dependencies.
`ifndef LOCKED_BACKGROUND_SUBTRACTOR_DEFINES_SVH
`define LOCKED_BACKGROUND_SUBTRACTOR_DEFINES_SVH

// Same-cycle implication, disabled while dis is high.
`define LBS_ASSERT_IMPL(lbl, dis, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while dis is high.
`define LBS_ASSERT_NEXT(lbl, dis, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/lbs_pkg.sv
// Shared types and constants of the locked background subtractor.
// No dependencies; imported by the classify, update, top-level and checker modules.
`timescale 1ns / 1ps
`default_nettype none

package lbs_pkg;

  localparam int PIXEL_W  = 8;
  localparam int IDX_W    = 17;
  localparam int THRESH_W = 9;
  localparam int LIMIT_W  = 16;
  localparam int ALPHA_W  = 9;
  localparam int PROD_W   = 17;
  localparam int LABEL_W  = 2;
  localparam int CFG_AW   = 4;
  localparam int CFG_DW   = 32;

  localparam logic OP_PROCESS = 1'b0;
  localparam logic OP_PRIME   = 1'b1;

  localparam logic [LABEL_W-1:0] LABEL_BG     = 2'd0;
  localparam logic [LABEL_W-1:0] LABEL_SHADOW = 2'd1;
  localparam logic [LABEL_W-1:0] LABEL_FG     = 2'd2;

  // register index codes, paddr[3:2]
  localparam logic [1:0] REG_DIFF_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_WARM_START     = 2'd1;
  localparam logic [1:0] REG_GHOST_LIMIT    = 2'd2;
  localparam logic [1:0] REG_BLEND_ALPHA    = 2'd3;

  localparam logic [THRESH_W-1:0] DIFF_THRESHOLD_RST = 9'd30;
  localparam logic [LIMIT_W-1:0]  WARM_START_RST     = 16'd10;
  localparam logic [LIMIT_W-1:0]  GHOST_LIMIT_RST    = 16'd100;
  localparam logic [ALPHA_W-1:0]  BLEND_ALPHA_RST    = 9'd13;
  localparam logic [ALPHA_W-1:0]  ALPHA_ONE          = 9'd256;

  typedef struct packed {
    logic opcode;
    logic in_range;
    logic shadow;
  } lbs_ctrl_t;

endpackage

`default_nettype wire

FILE: design/lbs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module lbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: design/lbs_classify.sv
// Stage 2 load: gray difference against threshold, run counter increment.
// Depends on lbs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lbs_classify #(
  parameter int COUNT_WIDTH = 16,
  parameter int ADDR_W      = 17
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  lbs_pkg::lbs_ctrl_t            in_ctrl,
  input  logic [ADDR_W-1:0]             in_addr,
  input  logic [lbs_pkg::PIXEL_W-1:0]   in_pixel,
  input  logic [lbs_pkg::PIXEL_W-1:0]   in_bg,
  input  logic [COUNT_WIDTH-1:0]        in_bg_count,
  input  logic [COUNT_WIDTH-1:0]        in_fg_count,
  input  logic                          in_lock,
  input  logic [lbs_pkg::THRESH_W-1:0]  diff_threshold,
  output logic                          out_valid,
  output lbs_pkg::lbs_ctrl_t            out_ctrl,
  output logic [ADDR_W-1:0]             out_addr,
  output logic [lbs_pkg::PIXEL_W-1:0]   out_pixel,
  output logic [lbs_pkg::PIXEL_W-1:0]   out_bg,
  output logic                          out_lock,
  output logic                          out_hit,
  output logic [COUNT_WIDTH-1:0]        out_count
);
  import lbs_pkg::*;

  logic [PIXEL_W-1:0]     diff;
  logic                   hit;
  logic [COUNT_WIDTH-1:0] count_inc;

  assign diff      = (in_bg >= in_pixel) ? (in_bg - in_pixel) : (in_pixel - in_bg);
  assign hit       = ({1'b0, diff} < diff_threshold);
  // counters wrap at 2^COUNT_WIDTH
  assign count_inc = hit ? (in_bg_count + COUNT_WIDTH'(1)) : (in_fg_count + COUNT_WIDTH'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_ctrl  <= in_ctrl;
      out_addr  <= in_addr;
      out_pixel <= in_pixel;
      out_bg    <= in_bg;
      out_lock  <= in_lock;
      out_hit   <= hit;
      out_count <= count_inc;
    end
  end

endmodule

`default_nettype wire

FILE: design/lbs_update.sv
// Stage 3 load: limit checks, new lock and counters, blend products.
// Depends on lbs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lbs_update #(
  parameter int COUNT_WIDTH = 16,
  parameter int ADDR_W      = 17
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  lbs_pkg::lbs_ctrl_t           in_ctrl,
  input  logic [ADDR_W-1:0]            in_addr,
  input  logic [lbs_pkg::PIXEL_W-1:0]  in_pixel,
  input  logic [lbs_pkg::PIXEL_W-1:0]  in_bg,
  input  logic                         in_lock,
  input  logic                         in_hit,
  input  logic [COUNT_WIDTH-1:0]       in_count,
  input  logic [lbs_pkg::LIMIT_W-1:0]  warm_start_limit,
  input  logic [lbs_pkg::LIMIT_W-1:0]  ghost_limit,
  input  logic [lbs_pkg::ALPHA_W-1:0]  blend_alpha,
  output logic                         out_valid,
  output lbs_pkg::lbs_ctrl_t           out_ctrl,
  output logic [ADDR_W-1:0]            out_addr,
  output logic [lbs_pkg::PIXEL_W-1:0]  out_pixel,
  output logic                         out_hit,
  output logic                         out_lock,
  output logic [COUNT_WIDTH-1:0]       out_bg_count,
  output logic [COUNT_WIDTH-1:0]       out_fg_count,
  output logic [lbs_pkg::PROD_W-1:0]   out_prod_new,
  output logic [lbs_pkg::PROD_W-1:0]   out_prod_old
);
  import lbs_pkg::*;

  localparam int CMP_W = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;

  logic                   over;
  logic                   lock_new;
  logic [COUNT_WIDTH-1:0] count_new;
  logic [COUNT_WIDTH-1:0] bg_count;
  logic [COUNT_WIDTH-1:0] fg_count;
  logic [ALPHA_W-1:0]     alpha;
  logic [ALPHA_W-1:0]     alpha_inv;

  assign over = in_hit ? (CMP_W'(in_count) > CMP_W'(warm_start_limit))
                       : (CMP_W'(in_count) > CMP_W'(ghost_limit));
  assign count_new = over ? '0 : in_count;

  always_comb begin
    if (in_ctrl.opcode == OP_PRIME) begin
      lock_new = 1'b0;
      bg_count = '0;
      fg_count = '0;
    end else if (in_hit) begin
      lock_new = over;
      bg_count = count_new;
      fg_count = '0;
    end else begin
      // ghost run: lock kept once the foreground run expires
      lock_new = over ? in_lock : 1'b1;
      bg_count = '0;
      fg_count = count_new;
    end
  end

  assign alpha     = (blend_alpha > ALPHA_ONE) ? ALPHA_ONE : blend_alpha;
  assign alpha_inv = ALPHA_ONE - alpha;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_ctrl     <= in_ctrl;
      out_addr     <= in_addr;
      out_pixel    <= in_pixel;
      out_hit      <= in_hit;
      out_lock     <= lock_new;
      out_bg_count <= bg_count;
      out_fg_count <= fg_count;
      out_prod_new <= PROD_W'(alpha) * PROD_W'(in_pixel);
      out_prod_old <= PROD_W'(alpha_inv) * PROD_W'(in_bg);
    end
  end

endmodule

`default_nettype wire

FILE: design/locked_background_subtractor.sv
// Top level of the locked background subtractor: input stage, state RAM,
// hazard interlock, final blend, output register and APB registers.
// Depends on lbs_pkg, lbs_ram, lbs_classify and lbs_update.
//
//  channel   | direction | handshake               | payload
//  ----------+-----------+-------------------------+--------------------------------
//  s_*       | in        | s_tvalid / s_tready     | pixel item, opcode in s_tuser
//  m_*       | out       | m_tvalid / m_tready     | label, lock, new background
//  APB       | in        | psel, penable, pready=1 | 4 registers at 0x0..0xC
//
//  One item per cycle when no hazard or output stall holds the flow; the result passes
//  from stage 1 (beside the RAM read) through classify, update and the output register.
//  An item for a pixel still in flight (in stage 1, 2 or 3) waits until the earlier
//  one has written the state RAM back.
//  Reset clears valid bits and loads the configuration defaults only; the state RAM is not
//  cleared, so every pixel must be primed before it is processed; the block does not enforce this.
//  Stalls on m_tready fill empty stages first, then back up to s_tready.
`timescale 1ns / 1ps
`default_nettype none

module locked_background_subtractor #(
  parameter int PIXEL_COUNT = 131072,
  parameter int COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // pixel_index[16:0], gray_pixel[24:17], shadow_mark[25]
  input  logic [0:0]  s_tuser,   // opcode[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // is_foreground[0], lock_state[1], fused_label[3:2],
                                 // background_out[11:4]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lbs_pkg::*;

  localparam int ADDR_W  = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
  localparam int EXT_W   = (ADDR_W > IDX_W) ? ADDR_W : IDX_W;
  localparam int STATE_W = PIXEL_W + 2 * COUNT_WIDTH + 1;

  // ---------------- configuration registers ----------------
  logic [THRESH_W-1:0] diff_threshold;
  logic [LIMIT_W-1:0]  warm_start_limit;
  logic [LIMIT_W-1:0]  ghost_limit;
  logic [ALPHA_W-1:0]  blend_alpha;
  logic                cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      diff_threshold   <= DIFF_THRESHOLD_RST;
      warm_start_limit <= WARM_START_RST;
      ghost_limit      <= GHOST_LIMIT_RST;
      blend_alpha      <= BLEND_ALPHA_RST;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        REG_DIFF_THRESHOLD: diff_threshold   <= pwdata[THRESH_W-1:0];
        REG_WARM_START:     warm_start_limit <= pwdata[LIMIT_W-1:0];
        REG_GHOST_LIMIT:    ghost_limit      <= pwdata[LIMIT_W-1:0];
        REG_BLEND_ALPHA:    blend_alpha      <= pwdata[ALPHA_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_DIFF_THRESHOLD: prdata = CFG_DW'(diff_threshold);
      REG_WARM_START:     prdata = CFG_DW'(warm_start_limit);
      REG_GHOST_LIMIT:    prdata = CFG_DW'(ghost_limit);
      REG_BLEND_ALPHA:    prdata = CFG_DW'(blend_alpha);
    endcase
  end

  // ---------------- input unpack ----------------
  logic [IDX_W-1:0]   in_index;
  logic [EXT_W-1:0]   in_index_ext;
  logic [ADDR_W-1:0]  in_addr;
  logic [PIXEL_W-1:0] in_pixel;
  lbs_ctrl_t          in_ctrl;

  assign in_index         = s_tdata[16:0];
  assign in_pixel         = s_tdata[24:17];
  assign in_index_ext     = EXT_W'(in_index);
  assign in_addr          = in_index_ext[ADDR_W-1:0];
  assign in_ctrl.opcode   = s_tuser[0];
  assign in_ctrl.shadow   = s_tdata[25];
  assign in_ctrl.in_range = (32'(in_index) < 32'(PIXEL_COUNT));

  // ---------------- pipeline flow ----------------
  // stage 1: item beside the RAM read; stage 2: classified; stage 3: updated
  logic en1, en2, en3, en_out;
  logic v1, v2, v3;
  logic hazard, accept;

  lbs_ctrl_t          ctrl1, ctrl2, ctrl3;
  logic [ADDR_W-1:0]  addr1, addr2, addr3;
  logic [PIXEL_W-1:0] pixel1;

  assign en_out = ~m_tvalid | m_tready;
  assign en3    = ~v3 | en_out;
  assign en2    = ~v2 | en3;
  assign en1    = ~v1 | en2;

  // read-modify-write interlock: same pixel must not be read before write-back
  assign hazard = in_ctrl.in_range & (
                    (v1 & ctrl1.in_range & (addr1 == in_addr)) |
                    (v2 & ctrl2.in_range & (addr2 == in_addr)) |
                    (v3 & ctrl3.in_range & (addr3 == in_addr)));

  assign s_tready = en1 & ~hazard;
  assign accept   = s_tvalid & s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ctrl1  <= in_ctrl;
      addr1  <= in_addr;
      pixel1 <= in_pixel;
    end
  end

  // ---------------- per-pixel state RAM ----------------
  // word: {background, background run, foreground run, lock}
  logic [STATE_W-1:0] ram_rdata;
  logic [STATE_W-1:0] ram_wdata;
  logic               ram_we;

  lbs_ram #(
    .WIDTH (STATE_W),
    .DEPTH (PIXEL_COUNT)
  ) u_state_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr3),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (in_addr),
    .rdata (ram_rdata)
  );

  logic [PIXEL_W-1:0]     rd_bg;
  logic [COUNT_WIDTH-1:0] rd_bg_count;
  logic [COUNT_WIDTH-1:0] rd_fg_count;
  logic                   rd_lock;

  assign {rd_bg, rd_bg_count, rd_fg_count, rd_lock} = ram_rdata;

  // ---------------- stage 2 ----------------
  logic [PIXEL_W-1:0]     pixel2, bg2;
  logic                   lock2, hit2;
  logic [COUNT_WIDTH-1:0] count2;

  lbs_classify #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .ADDR_W      (ADDR_W)
  ) u_classify (
    .clk            (clk),
    .rst            (rst),
    .en             (en2),
    .in_valid       (v1),
    .in_ctrl        (ctrl1),
    .in_addr        (addr1),
    .in_pixel       (pixel1),
    .in_bg          (rd_bg),
    .in_bg_count    (rd_bg_count),
    .in_fg_count    (rd_fg_count),
    .in_lock        (rd_lock),
    .diff_threshold (diff_threshold),
    .out_valid      (v2),
    .out_ctrl       (ctrl2),
    .out_addr       (addr2),
    .out_pixel      (pixel2),
    .out_bg         (bg2),
    .out_lock       (lock2),
    .out_hit        (hit2),
    .out_count      (count2)
  );

  // ---------------- stage 3 ----------------
  logic [PIXEL_W-1:0]     pixel3;
  logic                   hit3, lock3;
  logic [COUNT_WIDTH-1:0] bg_count3, fg_count3;
  logic [PROD_W-1:0]      prod_new3, prod_old3;

  lbs_update #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .ADDR_W      (ADDR_W)
  ) u_update (
    .clk              (clk),
    .rst              (rst),
    .en               (en3),
    .in_valid         (v2),
    .in_ctrl          (ctrl2),
    .in_addr          (addr2),
    .in_pixel         (pixel2),
    .in_bg            (bg2),
    .in_lock          (lock2),
    .in_hit           (hit2),
    .in_count         (count2),
    .warm_start_limit (warm_start_limit),
    .ghost_limit      (ghost_limit),
    .blend_alpha      (blend_alpha),
    .out_valid        (v3),
    .out_ctrl         (ctrl3),
    .out_addr         (addr3),
    .out_pixel        (pixel3),
    .out_hit          (hit3),
    .out_lock         (lock3),
    .out_bg_count     (bg_count3),
    .out_fg_count     (fg_count3),
    .out_prod_new     (prod_new3),
    .out_prod_old     (prod_old3)
  );

  // ---------------- final blend and write-back ----------------
  logic [PROD_W-1:0]  blend_sum;
  logic [PIXEL_W-1:0] bg_new;
  logic               fg3;
  logic [LABEL_W-1:0] label3;

  // sum never exceeds 256*255, so bits 15:8 hold the truncated average
  assign blend_sum = prod_new3 + prod_old3;
  // unlocked (and primed) pixels copy the new gray level
  assign bg_new    = lock3 ? blend_sum[15:8] : pixel3;
  assign fg3       = (ctrl3.opcode == OP_PROCESS) & ~hit3;

  always_comb begin
    if (ctrl3.opcode == OP_PRIME) begin
      label3 = LABEL_BG;
    end else if (ctrl3.shadow) begin
      label3 = LABEL_SHADOW;
    end else if (fg3) begin
      label3 = LABEL_FG;
    end else begin
      label3 = LABEL_BG;
    end
  end

  // written as the item leaves stage 3, once only
  assign ram_we    = v3 & en_out & ctrl3.in_range;
  assign ram_wdata = {bg_new, bg_count3, fg_count3, lock3};

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en_out) begin
      m_tvalid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      if (ctrl3.in_range) begin
        m_tdata <= {4'd0, bg_new, label3, lock3, fg3};
      end else begin
        // index beyond the store: all-zero result
        m_tdata <= '0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/lbs_checker.sv
// Port-level checks of the locked background subtractor, bound to the top.
// Depends on lbs_pkg and locked_background_subtractor_defines.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "locked_background_subtractor_defines.svh"

module lbs_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [15:0] m_tdata,
  input wire logic        psel,
  input wire logic        penable,
  input wire logic        pwrite,
  input wire logic        pready,
  input wire logic [3:0]  paddr,
  input wire logic [31:0] pwdata,
  input wire logic [31:0] prdata
);
  import lbs_pkg::*;

  logic               out_stall;
  logic               warm_sel;
  logic               warm_write;
  logic               warm_written;
  logic [LIMIT_W-1:0] warm_wdata;
  logic               warm_read_ok;

  assign out_stall    = m_tvalid && !m_tready;
  assign warm_sel     = (paddr[3:2] == REG_WARM_START);
  assign warm_write   = psel && penable && pwrite && pready && warm_sel;
  assign warm_read_ok = (prdata[LIMIT_W-1:0] == warm_wdata);

  // registered: whether the previous cycle wrote the warm start limit, and its pwdata
  always_ff @(posedge clk) begin
    if (rst) begin
      warm_written <= 1'b0;
    end else begin
      warm_written <= warm_write;
    end
    warm_wdata <= pwdata[LIMIT_W-1:0];
  end

  // stalled result holds
  `LBS_ASSERT_NEXT(a_out_hold, rst, out_stall, m_tvalid && $stable(m_tdata), "result moved")

  // reset empties the output register
  `LBS_ASSERT_NEXT(a_reset_clears, 1'b0, rst, !m_tvalid, "result valid after reset")

  // written warm start limit reads back on the next cycle
  `LBS_ASSERT_IMPL(a_cfg_readback, rst, warm_written && warm_sel, warm_read_ok, "bad readback")

endmodule

bind locked_background_subtractor lbs_checker u_lbs_checker (.*);

`default_nettype wire
